// ===== rtl/vdt_pkg.sv =====
`default_nettype none

package vdt_pkg;

    localparam int VDT_MAX_VERTS    = 4096;
    localparam int VDT_HASH_BUCKETS = 8192;

    localparam int COORD_W = 64;
    localparam int INDEX_W = 12;
    localparam int ERR_W   = 2;
    localparam int OP_W    = 2;

    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMAP  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

    localparam logic [ERR_W-1:0] ERR_OK         = 2'd0;
    localparam logic [ERR_W-1:0] ERR_TABLE_FULL = 2'd1;
    localparam logic [ERR_W-1:0] ERR_ARRIVALS   = 2'd2;
    localparam logic [ERR_W-1:0] ERR_REMAP      = 2'd3;

    localparam logic [62:0] EXP_ALL = 63'h7FF0000000000000;

    // Kind of result the datapath is told to register.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_ZERO,
        RES_ERR_FULL,
        RES_ERR_ARR,
        RES_ERR_REMAP,
        RES_INSERT,
        RES_REMAP
    } res_t;

    typedef struct packed {
        logic latch;
        logic hash_load;
        logic probe_next;
        logic bucket_wr;
        logic take_hit;
        logic arrive_wr;
        logic clr_init;
        logic clr_step;
        res_t res;
    } vdt_cmd_t;

    typedef struct packed {
        logic arr_full;
        logic uniq_full;
        logic remap_bad;
        logic slot_empty;
        logic slot_hit;
        logic probe_last;
        logic clr_last;
    } vdt_status_t;

    function automatic logic is_nan(input logic [COORD_W-1:0] b);
        return b[62:0] > EXP_ALL;
    endfunction

    // Equality as doubles: both zeros match, a NaN matches nothing.
    function automatic logic same_double(input logic [COORD_W-1:0] a,
                                         input logic [COORD_W-1:0] b);
        logic res;
        if (is_nan(a) || is_nan(b))
            res = 1'b0;
        else if (a[62:0] == 63'd0 && b[62:0] == 63'd0)
            res = 1'b1;
        else
            res = (a == b);
        return res;
    endfunction

    function automatic logic [COORD_W-1:0] norm_zero(input logic [COORD_W-1:0] b);
        return (b[62:0] == 63'd0) ? '0 : b;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/vdt_ctrl.sv =====
`default_nettype none

module vdt_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [1:0]          op,
    input  wire vdt_pkg::vdt_status_t status,
    output vdt_pkg::vdt_cmd_t        cmd,
    output logic                     busy
);
    import vdt_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_HASH   = 8'b0000_0100,
        S_WAIT   = 8'b0000_1000,
        S_CMP    = 8'b0001_0000,
        S_ARRIVE = 8'b0010_0000,
        S_RWAIT  = 8'b0100_0000,
        S_ROUT   = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   clr_emit_reg, clr_emit_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_emit_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_emit_reg <= clr_emit_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        clr_emit_next = clr_emit_reg;
        cmd           = '0;
        cmd.res       = RES_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.latch = 1'b1;
                    unique case (op)
                        OP_INSERT:
                        begin
                            if (status.arr_full)
                                cmd.res = RES_ERR_ARR;
                            else
                                state_next = S_HASH;
                        end
                        OP_REMAP:
                        begin
                            if (status.remap_bad)
                                cmd.res = RES_ERR_REMAP;
                            else
                                state_next = S_RWAIT;
                        end
                        OP_CLEAR:
                        begin
                            cmd.clr_init  = 1'b1;
                            clr_emit_next = 1'b1;
                            state_next    = S_CLEAR;
                        end
                        default: cmd.res = RES_ZERO;
                    endcase
                end
            end
            S_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                begin
                    if (clr_emit_reg)
                        cmd.res = RES_ZERO;
                    clr_emit_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            S_HASH:
            begin
                cmd.hash_load = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT: state_next = S_CMP;
            S_CMP:
            begin
                if (status.slot_empty)
                begin
                    if (status.uniq_full)
                    begin
                        cmd.res    = RES_ERR_FULL;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        cmd.bucket_wr = 1'b1;
                        state_next    = S_ARRIVE;
                    end
                end
                else if (status.slot_hit)
                begin
                    cmd.take_hit = 1'b1;
                    state_next   = S_ARRIVE;
                end
                else if (status.probe_last)
                begin
                    cmd.res    = RES_ERR_FULL;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_WAIT;
                end
            end
            S_ARRIVE:
            begin
                cmd.arrive_wr = 1'b1;
                cmd.res       = RES_INSERT;
                state_next    = S_IDLE;
            end
            S_RWAIT: state_next = S_ROUT;
            S_ROUT:
            begin
                cmd.res    = RES_REMAP;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign busy = (state_reg != S_IDLE);

    a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) && !status.clr_last |-> cmd.res == RES_NONE)
        else $error("result issued in the middle of a clearing pass");

    a_probe_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_next |=> state_reg == S_WAIT)
        else $error("probe step not followed by a read wait");

    a_insert_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ARRIVE) |=> !busy)
        else $error("controller did not return to idle after an insert");

endmodule

`default_nettype wire

// ===== rtl/vdt_datapath.sv =====
`default_nettype none

module vdt_datapath #(
    parameter int MAX_VERTS    = vdt_pkg::VDT_MAX_VERTS,
    parameter int HASH_BUCKETS = vdt_pkg::VDT_HASH_BUCKETS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire vdt_pkg::vdt_cmd_t             cmd,
    output vdt_pkg::vdt_status_t               status,
    input  wire logic [vdt_pkg::COORD_W-1:0]   coord_x,
    input  wire logic [vdt_pkg::COORD_W-1:0]   coord_y,
    input  wire logic [vdt_pkg::COORD_W-1:0]   coord_z,
    input  wire logic [vdt_pkg::INDEX_W-1:0]   old_index,
    output logic                               done,
    output logic [vdt_pkg::INDEX_W-1:0]        new_id,
    output logic                               is_new,
    output logic [vdt_pkg::ERR_W-1:0]          error
);
    import vdt_pkg::*;

    localparam int IDW   = $clog2(MAX_VERTS);
    localparam int CW    = $clog2(MAX_VERTS + 1);
    localparam int HBW   = $clog2(HASH_BUCKETS);
    localparam int PCW   = $clog2(HASH_BUCKETS + 1);
    localparam int XW    = (CW > INDEX_W) ? CW : INDEX_W;
    localparam int WORD_W = 1 + IDW + 3 * COORD_W;

    // Bucket word: valid, id, x, y, z.
    logic [WORD_W-1:0]  bucket_mem [HASH_BUCKETS];
    logic [WORD_W-1:0]  bucket_q;
    logic [IDW-1:0]     arrival_mem [MAX_VERTS];
    logic [IDW-1:0]     arr_q;

    logic [COORD_W-1:0] x_reg, y_reg, z_reg;
    logic [INDEX_W-1:0] idx_reg;
    logic [HBW-1:0]     pos_reg;
    logic [PCW-1:0]     probe_reg;
    logic [HBW-1:0]     clr_reg;
    logic [CW-1:0]      uniq_reg, arr_reg;
    logic [IDW-1:0]     id_reg;
    logic               fresh_reg;
    logic               done_reg;
    logic [INDEX_W-1:0] new_id_reg, new_id_next;
    logic               is_new_reg, is_new_next;
    logic [ERR_W-1:0]   error_reg, error_next;

    logic [HBW-1:0]     fold;
    logic [HBW:0]       fold_ext;
    logic [HBW-1:0]     pos_start;
    logic               wr_en;
    logic [HBW-1:0]     wr_addr;
    logic [WORD_W-1:0]  wr_data;
    logic               slot_valid;
    logic [IDW-1:0]     slot_id;

    // Hash: XOR fold of the zero-normalised key, reduced once into range.
    always_comb
    begin
        logic [COORD_W-1:0] kx, ky, kz;
        kx   = norm_zero(x_reg);
        ky   = norm_zero(y_reg);
        kz   = norm_zero(z_reg);
        fold = '0;
        for (int i = 0; i < COORD_W; i++)
            fold[i % HBW] = fold[i % HBW] ^ kx[i] ^ ky[(i + 21) % COORD_W]
                            ^ kz[(i + 42) % COORD_W];
    end

    assign fold_ext  = {1'b0, fold};
    assign pos_start = (fold_ext >= (HBW+1)'(HASH_BUCKETS))
                       ? HBW'(fold_ext - (HBW+1)'(HASH_BUCKETS)) : fold;

    assign slot_valid = bucket_q[WORD_W-1];
    assign slot_id    = bucket_q[WORD_W-2 -: IDW];

    always_comb
    begin
        status.arr_full   = (arr_reg == CW'(MAX_VERTS));
        status.uniq_full  = (uniq_reg == CW'(MAX_VERTS));
        status.remap_bad  = (XW'(old_index) >= XW'(arr_reg));
        status.slot_empty = !slot_valid;
        status.slot_hit   = slot_valid
                            && same_double(x_reg, bucket_q[3*COORD_W-1 -: COORD_W])
                            && same_double(y_reg, bucket_q[2*COORD_W-1 -: COORD_W])
                            && same_double(z_reg, bucket_q[COORD_W-1:0]);
        status.probe_last = (probe_reg == PCW'(HASH_BUCKETS - 1));
        status.clr_last   = (clr_reg == HBW'(HASH_BUCKETS - 1));
    end

    assign wr_en   = cmd.bucket_wr || cmd.clr_step;
    assign wr_addr = cmd.clr_step ? clr_reg : pos_reg;
    assign wr_data = cmd.clr_step ? '0
                     : {1'b1, IDW'(uniq_reg), x_reg, y_reg, z_reg};

    always_ff @(posedge clk)
    begin
        if (wr_en)
            bucket_mem[wr_addr] <= wr_data;
        bucket_q <= bucket_mem[pos_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.arrive_wr)
            arrival_mem[arr_reg[IDW-1:0]] <= id_reg;
        arr_q <= arrival_mem[IDW'(idx_reg)];
    end

    always_comb
    begin
        new_id_next = '0;
        is_new_next = 1'b0;
        error_next  = ERR_OK;
        case (cmd.res)
            RES_ERR_FULL:  error_next = ERR_TABLE_FULL;
            RES_ERR_ARR:   error_next = ERR_ARRIVALS;
            RES_ERR_REMAP: error_next = ERR_REMAP;
            RES_INSERT:
            begin
                new_id_next = INDEX_W'(id_reg);
                is_new_next = fresh_reg;
            end
            RES_REMAP:     new_id_next = INDEX_W'(arr_q);
            default:       ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            x_reg   <= coord_x;
            y_reg   <= coord_y;
            z_reg   <= coord_z;
            idx_reg <= old_index;
        end
        if (cmd.hash_load)
            pos_reg <= pos_start;
        else if (cmd.probe_next)
            pos_reg <= (pos_reg == HBW'(HASH_BUCKETS - 1)) ? '0 : pos_reg + 1'b1;
        if (cmd.bucket_wr)
        begin
            id_reg    <= IDW'(uniq_reg);
            fresh_reg <= 1'b1;
        end
        else if (cmd.take_hit)
        begin
            id_reg    <= slot_id;
            fresh_reg <= 1'b0;
        end
        new_id_reg <= new_id_next;
        is_new_reg <= is_new_next;
        error_reg  <= error_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            probe_reg <= '0;
            clr_reg   <= '0;
            uniq_reg  <= '0;
            arr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (cmd.res != RES_NONE);
            if (cmd.hash_load)
                probe_reg <= '0;
            else if (cmd.probe_next)
                probe_reg <= probe_reg + 1'b1;
            if (cmd.clr_init)
            begin
                clr_reg  <= '0;
                uniq_reg <= '0;
                arr_reg  <= '0;
            end
            else
            begin
                if (cmd.clr_step)
                    clr_reg <= status.clr_last ? '0 : clr_reg + 1'b1;
                if (cmd.bucket_wr)
                    uniq_reg <= uniq_reg + 1'b1;
                if (cmd.arrive_wr)
                    arr_reg <= arr_reg + 1'b1;
            end
        end
    end

    assign done   = done_reg;
    assign new_id = new_id_reg;
    assign is_new = is_new_reg;
    assign error  = error_reg;

    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.bucket_wr |-> status.slot_empty && !status.uniq_full)
        else $error("bucket written while occupied or ids exhausted");

    a_arrive_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.arrive_wr |-> !status.arr_full)
        else $error("arrival recorded beyond capacity");

    a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.probe_next |-> !status.probe_last)
        else $error("probe walked past the whole table");

endmodule

`default_nettype wire

// ===== rtl/vertex_dedup_index_table_unit.sv =====
`default_nettype none

// Hashed vertex deduplication. A command is taken when start is high and busy
// is low; its single result appears on new_id, is_new and error for exactly one
// cycle with done high, and the receiver cannot stall it. An insert hashes the
// key, waits on the registered read of the bucket memory and compares, and
// repeats the wait and compare for each further bucket its linear probe visits
// before it records the arrival; a remap waits on the registered read of the
// arrival memory; unused op codes answer straight from idle.
// A clear sweeps the bucket memory one entry a cycle and then answers. After
// reset the same sweep runs with busy high before the first command is taken.
module vertex_dedup_index_table_unit #(
    parameter int MAX_VERTS    = vdt_pkg::VDT_MAX_VERTS,
    parameter int HASH_BUCKETS = vdt_pkg::VDT_HASH_BUCKETS
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [vdt_pkg::OP_W-1:0]      op,
    input  wire logic [vdt_pkg::COORD_W-1:0]   coord_x,
    input  wire logic [vdt_pkg::COORD_W-1:0]   coord_y,
    input  wire logic [vdt_pkg::COORD_W-1:0]   coord_z,
    input  wire logic [vdt_pkg::INDEX_W-1:0]   old_index,
    output logic                               done,
    output logic [vdt_pkg::INDEX_W-1:0]        new_id,
    output logic                               is_new,
    output logic [vdt_pkg::ERR_W-1:0]          error
);
    import vdt_pkg::*;

    vdt_cmd_t    cmd;
    vdt_status_t status;

    vdt_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (op),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    vdt_datapath #(
        .MAX_VERTS    (MAX_VERTS),
        .HASH_BUCKETS (HASH_BUCKETS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .coord_x   (coord_x),
        .coord_y   (coord_y),
        .coord_z   (coord_z),
        .old_index (old_index),
        .done      (done),
        .new_id    (new_id),
        .is_new    (is_new),
        .error     (error)
    );

endmodule

`default_nettype wire
